// File: sv/bvms_pkg.sv
// Shared types and constants of the binned vector mean / deviation unit.
// Depends on nothing; imported by binned_vector_mean_stddev_unit and its bench.
package bvms_pkg;

  localparam int SLICES  = 32;
  localparam int SLICE_W = $clog2(SLICES);

  localparam logic [15:0] SAMPLE_COUNT_RESET = 16'd1;
  localparam logic [15:0] TOLERANCE_RESET    = 16'd17;

  // register index, taken from paddr[2]
  localparam logic REG_SAMPLE_COUNT = 1'b0;
  localparam logic REG_TOLERANCE    = 1'b1;

  localparam logic OP_ACCUMULATE = 1'b0;
  localparam logic OP_NORMALIZE  = 1'b1;

  localparam logic [23:0] MEAN_POS_MAX = 24'h7FFFFF;
  localparam logic [23:0] MEAN_NEG_MIN = 24'h800000;
  localparam logic [23:0] U24_MAX      = 24'hFFFFFF;
  localparam logic [61:0] U62_MAX      = {62{1'b1}};

  typedef struct packed {
    logic               opcode;
    logic [4:0]         slice_index;
    logic signed [23:0] x_value;
    logic signed [23:0] y_value;
    logic signed [23:0] z_value;
    logic [45:0]        x_square;
    logic [45:0]        y_square;
    logic [45:0]        z_square;
  } req_t;

  typedef struct packed {
    logic [4:0]         result_slice;
    logic signed [23:0] mean_x;
    logic signed [23:0] mean_y;
    logic signed [23:0] mean_z;
    logic [23:0]        mean_magnitude;
    logic [23:0]        sdev_x;
    logic [23:0]        sdev_y;
    logic [23:0]        sdev_z;
    logic [23:0]        sdev_magnitude;
    logic [3:0]         negative_variance_flags;
  } rsp_t;

  typedef struct packed {
    logic [39:0] sum_x;
    logic [39:0] sum_y;
    logic [39:0] sum_z;
    logic [39:0] sum_magnitude;
    logic [61:0] sum_x_square;
    logic [61:0] sum_y_square;
    logic [61:0] sum_z_square;
    logic [63:0] sum_magnitude_square;
  } row_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROOT,
    ST_ACC,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_END,
    ST_MUL,
    ST_SUB,
    ST_DEV_END,
    ST_FIN
  } state_t;

  // signed 40-bit add, clamped to the 40-bit range
  function automatic logic [39:0] sat_add40(logic [39:0] a, logic [23:0] b);
    logic [40:0] t;
    t = {a[39], a} + {{17{b[23]}}, b};
    unique case (t[40:39])
      2'b01:   return {1'b0, {39{1'b1}}};
      2'b10:   return {1'b1, {39{1'b0}}};
      default: return t[39:0];
    endcase
  endfunction

endpackage

// File: sv/binned_vector_mean_stddev_unit.sv
// Top level of the binned vector mean / standard deviation unit.
// Depends on bvms_pkg (types, state codes, saturating add).
//
//  channel   | signals                                   | moves
//  ----------+-------------------------------------------+------------------------
//  request   | req_valid, req_stall, req_data (req_t)     | accumulate / normalize
//  result    | rsp_valid, rsp_stall, rsp_data (rsp_t)     | statistics of one slice
//  config    | psel penable pwrite paddr pwdata prdata    | sample_count, tolerance
//
// One request at a time; req_stall is high from acceptance until the work ends.
// Accumulate: load the row, run the 32-step shared square-root unit, then write the row.
// Normalize: eight 64-step divisions by sample_count on the shared 1-bit divider,
// then per component a 24x24 multiply, a compare and up to 32 square-root steps.
// Reset clears control and the per-slice valid bits and loads the register defaults (no sweep).
// A held result on a stalled output parks the sequencer at its last step.
module binned_vector_mean_stddev_unit
  import bvms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req_data,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t state, state_next;

  logic [15:0] sample_count;
  logic [15:0] variance_tolerance;
  logic [15:0] divisor;

  // per-slice sums; a row whose valid bit is low reads as zero
  row_t              sums [SLICES];
  logic [SLICES-1:0] row_valid;

  req_t req;
  row_t row;
  logic [SLICE_W-1:0] idx;

  logic [2:0]  k;        // division index, then deviation index
  logic [5:0]  cnt;      // step counter of the shared unit

  logic [63:0] div_q;    // dividend shifting out, quotient shifting in
  logic [15:0] div_r;
  logic        div_neg;

  logic [63:0] sq_v;
  logic [34:0] sq_rem;
  logic [31:0] sq_root;

  logic [23:0] mean_val [4];
  logic [23:0] mean_abs [4];
  logic [63:0] msq      [4];
  logic [23:0] sdev     [4];
  logic [3:0]  flags;
  logic [47:0] m2;

  logic        cfg_write;

  // shared unit: one divide step and one square-root step
  logic [16:0] div_sh;
  logic        div_bit;
  logic [15:0] div_r_next;
  logic [34:0] rem_sh, root_test, sq_rem_next;
  logic [31:0] sq_root_next;

  // dividend selection and accumulate row
  logic [63:0] dividend;
  logic        dividend_neg;
  logic [39:0] sel_signed;
  logic [47:0] mag2;
  row_t        row_next;
  logic [62:0] ux, uy, uz;
  logic [40:0] um;
  logic [64:0] umm;
  logic [63:0] dev_diff;

  assign idx       = req.slice_index[SLICE_W-1:0];
  assign divisor   = (sample_count == '0) ? 16'd1 : sample_count;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_TOLERANCE) ? {16'b0, variance_tolerance}
                                                 : {16'b0, sample_count};
  assign req_stall = (state != ST_IDLE);
  assign mag2      = {2'b0, req.x_square} + {2'b0, req.y_square} + {2'b0, req.z_square};

  always_comb begin
    div_sh       = {div_r, div_q[63]};
    div_bit      = (div_sh >= {1'b0, divisor});
    div_r_next   = div_bit ? 16'(div_sh - {1'b0, divisor}) : div_sh[15:0];
    rem_sh       = {sq_rem[32:0], sq_v[63:62]};
    root_test    = {1'b0, sq_root, 2'b01};
    if (rem_sh >= root_test) begin
      sq_rem_next  = rem_sh - root_test;
      sq_root_next = {sq_root[30:0], 1'b1};
    end else begin
      sq_rem_next  = rem_sh;
      sq_root_next = {sq_root[30:0], 1'b0};
    end
  end

  // pick the sum to divide; signed sums are divided as magnitudes
  always_comb begin
    unique case (k[1:0])
      2'd0:    sel_signed = row.sum_x;
      2'd1:    sel_signed = row.sum_y;
      default: sel_signed = row.sum_z;
    endcase
    dividend_neg = 1'b0;
    priority if (k == 3'd3) begin
      dividend = {24'b0, row.sum_magnitude};
    end else if (k == 3'd4) begin
      dividend = {2'b0, row.sum_x_square};
    end else if (k == 3'd5) begin
      dividend = {2'b0, row.sum_y_square};
    end else if (k == 3'd6) begin
      dividend = {2'b0, row.sum_z_square};
    end else if (k == 3'd7) begin
      dividend = row.sum_magnitude_square;
    end else begin
      dividend_neg = sel_signed[39];
      dividend     = {24'b0, sel_signed[39] ? 40'(~sel_signed + 40'd1) : sel_signed};
    end
  end

  always_comb begin
    row_next.sum_x = sat_add40(row.sum_x, req.x_value);
    row_next.sum_y = sat_add40(row.sum_y, req.y_value);
    row_next.sum_z = sat_add40(row.sum_z, req.z_value);
    ux  = {1'b0, row.sum_x_square} + {17'b0, req.x_square};
    uy  = {1'b0, row.sum_y_square} + {17'b0, req.y_square};
    uz  = {1'b0, row.sum_z_square} + {17'b0, req.z_square};
    um  = {1'b0, row.sum_magnitude} + {9'b0, sq_root};
    umm = {1'b0, row.sum_magnitude_square} + {17'b0, mag2};
    row_next.sum_x_square = ux[62] ? U62_MAX : ux[61:0];
    row_next.sum_y_square = uy[62] ? U62_MAX : uy[61:0];
    row_next.sum_z_square = uz[62] ? U62_MAX : uz[61:0];
    row_next.sum_magnitude = um[40] ? {40{1'b1}} : um[39:0];
    row_next.sum_magnitude_square = umm[64] ? {64{1'b1}} : umm[63:0];
  end

  assign dev_diff = {16'b0, m2} - msq[k[1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid && (int'(req_data.slice_index) < SLICES)) state_next = ST_LOAD;
      end
      ST_LOAD:     state_next = (req.opcode == OP_ACCUMULATE) ? ST_ROOT : ST_DIV_INIT;
      ST_ROOT: begin
        if (cnt == 6'd31) state_next = (req.opcode == OP_ACCUMULATE) ? ST_ACC : ST_DEV_END;
      end
      ST_ACC:      state_next = ST_IDLE;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == 6'd63) state_next = ST_DIV_END;
      end
      ST_DIV_END:  state_next = (k == 3'd7) ? ST_MUL : ST_DIV_INIT;
      ST_MUL:      state_next = ST_SUB;
      ST_SUB:      state_next = (msq[k[1:0]] >= {16'b0, m2}) ? ST_ROOT : ST_DEV_END;
      ST_DEV_END:  state_next = (k == 3'd3) ? ST_FIN : ST_MUL;
      ST_FIN: begin
        if (!rsp_valid || !rsp_stall) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  // configuration, output valid and per-slice valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count       <= SAMPLE_COUNT_RESET;
      variance_tolerance <= TOLERANCE_RESET;
      rsp_valid          <= 1'b0;
      row_valid          <= '0;
    end else begin
      if (cfg_write) begin
        unique case (paddr[2])
          REG_SAMPLE_COUNT: sample_count       <= pwdata[15:0];
          REG_TOLERANCE:    variance_tolerance <= pwdata[15:0];
          default:          ;
        endcase
      end
      if (state == ST_FIN && (!rsp_valid || !rsp_stall)) begin
        rsp_valid      <= 1'b1;
        row_valid[idx] <= 1'b0;   // normalize clears the slice
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (state == ST_ACC) row_valid[idx] <= 1'b1;
    end
  end

  // datapath of the sequencer
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_valid) req <= req_data;
      end
      ST_LOAD: begin
        row     <= row_valid[idx] ? sums[idx] : '0;
        sq_v    <= {16'b0, mag2};
        sq_rem  <= '0;
        sq_root <= '0;
        cnt     <= '0;
        k       <= '0;
        flags   <= '0;
      end
      ST_ROOT: begin
        sq_v    <= {sq_v[61:0], 2'b00};
        sq_rem  <= sq_rem_next;
        sq_root <= sq_root_next;
        cnt     <= cnt + 6'd1;
        if (cnt == 6'd31 && req.opcode == OP_NORMALIZE) begin
          sdev[k[1:0]] <= (sq_root_next[31:24] != '0) ? U24_MAX : sq_root_next[23:0];
        end
      end
      ST_ACC: begin
        sums[idx] <= row_next;
      end
      ST_DIV_INIT: begin
        div_q   <= dividend;
        div_neg <= dividend_neg;
        div_r   <= '0;
        cnt     <= '0;
      end
      ST_DIV: begin
        div_q <= {div_q[62:0], div_bit};
        div_r <= div_r_next;
        cnt   <= cnt + 6'd1;
      end
      ST_DIV_END: begin
        priority if (k[2]) begin
          msq[k[1:0]] <= div_q;
        end else if (k == 3'd3) begin
          mean_val[3] <= (div_q[63:24] != '0) ? U24_MAX : div_q[23:0];
          mean_abs[3] <= (div_q[63:24] != '0) ? U24_MAX : div_q[23:0];
        end else if (!div_neg) begin
          mean_val[k[1:0]] <= (div_q > 64'(MEAN_POS_MAX)) ? MEAN_POS_MAX : div_q[23:0];
          mean_abs[k[1:0]] <= (div_q > 64'(MEAN_POS_MAX)) ? MEAN_POS_MAX : div_q[23:0];
        end else begin
          mean_val[k[1:0]] <= (div_q > 64'(MEAN_NEG_MIN)) ? MEAN_NEG_MIN
                                                          : 24'(~div_q[23:0] + 24'd1);
          mean_abs[k[1:0]] <= (div_q > 64'(MEAN_NEG_MIN)) ? MEAN_NEG_MIN : div_q[23:0];
        end
        k <= (k == 3'd7) ? 3'd0 : k + 3'd1;
      end
      ST_MUL: begin
        m2 <= mean_abs[k[1:0]] * mean_abs[k[1:0]];
      end
      ST_SUB: begin
        sq_v    <= msq[k[1:0]] - {16'b0, m2};
        sq_rem  <= '0;
        sq_root <= '0;
        cnt     <= '0;
        if (msq[k[1:0]] < {16'b0, m2}) begin
          sdev[k[1:0]]  <= '0;
          flags[k[1:0]] <= (dev_diff > {48'b0, variance_tolerance});
        end
      end
      ST_DEV_END: begin
        k <= k + 3'd1;
      end
      ST_FIN: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_data.result_slice            <= req.slice_index;
          rsp_data.mean_x                  <= mean_val[0];
          rsp_data.mean_y                  <= mean_val[1];
          rsp_data.mean_z                  <= mean_val[2];
          rsp_data.mean_magnitude          <= mean_val[3];
          rsp_data.sdev_x                  <= sdev[0];
          rsp_data.sdev_y                  <= sdev[1];
          rsp_data.sdev_z                  <= sdev[2];
          rsp_data.sdev_magnitude          <= sdev[3];
          rsp_data.negative_variance_flags <= flags;
        end
      end
      default: ;
    endcase
  end

  // a new result only ever comes out of the final step of a normalize
  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_FIN)
    else $error("result raised outside the final step");

  // a flagged component always reports a zero deviation
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_data.negative_variance_flags[0] && rsp_data.sdev_x != '0) &&
                  !(rsp_data.negative_variance_flags[1] && rsp_data.sdev_y != '0) &&
                  !(rsp_data.negative_variance_flags[2] && rsp_data.sdev_z != '0) &&
                  !(rsp_data.negative_variance_flags[3] && rsp_data.sdev_magnitude != '0))
    else $error("flagged variance with nonzero deviation");

  // the square-root unit never runs beyond its 32 steps
  a_root_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROOT |-> cnt < 6'd32)
    else $error("square-root step count overrun");

  // an accumulate writes its row straight after the last root step
  a_acc_after_root: assert property (@(posedge clk) disable iff (rst)
    state == ST_ACC |-> $past(state) == ST_ROOT && $past(cnt) == 6'd31)
    else $error("row written before the magnitude was ready");

endmodule

// File: sim/tb_binned_vector_mean_stddev_unit.sv
// Self-checking bench for binned_vector_mean_stddev_unit: accumulate and
// normalize requests, checked against a per-slice statistics model kept here.
// Depends on bvms_pkg and the unit's RTL only.
`timescale 1ns / 1ps

module tb_binned_vector_mean_stddev_unit;
  import bvms_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLDOFF_CYCLES = 3000;

  localparam longint SUM40_HI = 64'sd549755813887;
  localparam longint SUM40_LO = -64'sd549755813888;
  localparam longint unsigned USUM40_HI = 64'hFF_FFFF_FFFF;
  localparam longint unsigned USUM62_HI = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [45:0] SQ_MAX = {46{1'b1}};

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req_data;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  binned_vector_mean_stddev_unit dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // ---------------------------------------------------------------------
  // Statistics model: its own copy of the registers and per-slice sums.
  // ---------------------------------------------------------------------
  logic [15:0]      cfg_count;
  logic [15:0]      cfg_tolerance;
  longint           acc_x [SLICES];
  longint           acc_y [SLICES];
  longint           acc_z [SLICES];
  longint unsigned  acc_mag [SLICES];
  longint unsigned  acc_xsq [SLICES];
  longint unsigned  acc_ysq [SLICES];
  longint unsigned  acc_zsq [SLICES];
  longint unsigned  acc_magsq [SLICES];

  rsp_t due_stats[$];   // statistics still owed by the unit, oldest first

  int errors;
  int requests_sent;
  int normalizes_sent;
  int results_seen;
  int flagged_results;

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned clamp_add(longint unsigned a, longint unsigned b,
                                                longint unsigned hi);
    if (a >= hi || b > hi - a) return hi;
    return a + b;
  endfunction

  function automatic longint clamp_mean(longint total, longint unsigned n);
    longint m;
    m = total / longint'(n);
    if (m > 64'sd8388607) return 64'sd8388607;
    if (m < -64'sd8388608) return -64'sd8388608;
    return m;
  endfunction

  // deviation from a mean square and a mean magnitude; raises flag past tolerance
  function automatic logic [23:0] spread(longint unsigned msq, longint unsigned mabs,
                                         output logic flag);
    longint unsigned m2;
    longint unsigned r;
    m2 = mabs * mabs;
    flag = 1'b0;
    if (msq >= m2) begin
      r = floor_sqrt(msq - m2);
      return (r > 64'hFF_FFFF) ? U24_MAX : r[23:0];
    end
    if (m2 - msq > longint'(cfg_tolerance)) flag = 1'b1;
    return '0;
  endfunction

  function automatic longint unsigned abs_of(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  task automatic clear_sums(int s);
    acc_x[s] = 0; acc_y[s] = 0; acc_z[s] = 0; acc_mag[s] = 0;
    acc_xsq[s] = 0; acc_ysq[s] = 0; acc_zsq[s] = 0; acc_magsq[s] = 0;
  endtask

  function automatic longint clamp40(longint v);
    if (v > SUM40_HI) return SUM40_HI;
    if (v < SUM40_LO) return SUM40_LO;
    return v;
  endfunction

  // Advance the model by one accepted request; queue the statistics it owes.
  task automatic update_statistics(req_t r);
    int s;
    longint unsigned xs, ys, zs, mag2, n, mmag;
    longint mx, my, mz;
    logic f;
    logic [64:0] wide;
    rsp_t st;
    s = r.slice_index;
    if (r.opcode == OP_ACCUMULATE) begin
      xs = r.x_square; ys = r.y_square; zs = r.z_square;
      acc_x[s] = clamp40(acc_x[s] + longint'(r.x_value));
      acc_y[s] = clamp40(acc_y[s] + longint'(r.y_value));
      acc_z[s] = clamp40(acc_z[s] + longint'(r.z_value));
      acc_xsq[s] = clamp_add(acc_xsq[s], xs, USUM62_HI);
      acc_ysq[s] = clamp_add(acc_ysq[s], ys, USUM62_HI);
      acc_zsq[s] = clamp_add(acc_zsq[s], zs, USUM62_HI);
      mag2 = xs + ys + zs;
      acc_mag[s] = clamp_add(acc_mag[s], floor_sqrt(mag2), USUM40_HI);
      wide = {1'b0, acc_magsq[s]} + {1'b0, mag2};
      acc_magsq[s] = wide[64] ? '1 : wide[63:0];
    end else begin
      n = (cfg_count == 0) ? 1 : cfg_count;
      mx = clamp_mean(acc_x[s], n);
      my = clamp_mean(acc_y[s], n);
      mz = clamp_mean(acc_z[s], n);
      mmag = acc_mag[s] / n;
      if (mmag > 64'hFF_FFFF) mmag = 64'hFF_FFFF;
      st.result_slice   = s[4:0];
      st.mean_x         = mx[23:0];
      st.mean_y         = my[23:0];
      st.mean_z         = mz[23:0];
      st.mean_magnitude = mmag[23:0];
      st.negative_variance_flags = '0;
      st.sdev_x = spread(acc_xsq[s] / n, abs_of(mx), f);
      st.negative_variance_flags[0] = f;
      st.sdev_y = spread(acc_ysq[s] / n, abs_of(my), f);
      st.negative_variance_flags[1] = f;
      st.sdev_z = spread(acc_zsq[s] / n, abs_of(mz), f);
      st.negative_variance_flags[2] = f;
      st.sdev_magnitude = spread(acc_magsq[s] / n, mmag, f);
      st.negative_variance_flags[3] = f;
      due_stats.push_back(st);
      clear_sums(s);
      normalizes_sent++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Request side: bursts of random length with random gaps between them.
  // ---------------------------------------------------------------------
  int burst_left;
  int idle_cycles;

  // result side: long hold-off on request, own stall pattern
  int holdoff_request;
  int holdoff_left;
  int pattern_left;
  int stall_pct;

  // Offer one request and hold it until the unit takes it. Called at a rising
  // edge; returns at the edge that accepted it, valid still high.
  task automatic send_request(req_t r);
    logic taken;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0 && req_valid) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req_data  <= r;
    do begin
      @(negedge clk);
      taken = !req_stall;
      @(posedge clk);
    end while (!taken);
    update_statistics(r);
    requests_sent++;
  endtask

  // Drop valid, wait for every owed result, then let an accumulate finish.
  task automatic drain;
    req_valid <= 1'b0;
    burst_left = 0;
    while (due_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Register port: write in setup and access cycles, read back to confirm.
  // ---------------------------------------------------------------------
  task automatic write_register(logic idx, logic [15:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= {16'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    if (prdata[15:0] !== value) begin
      $display("%0t register %0d read back: expected %h actual %h",
               $time, idx, value, prdata[15:0]);
      errors++;
    end
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    if (idx == REG_SAMPLE_COUNT) cfg_count = value;
    else cfg_tolerance = value;
  endtask

  function automatic req_t make_request(logic op, int s, int x, int y, int z,
                                        logic [45:0] xs, logic [45:0] ys, logic [45:0] zs);
    req_t r;
    r.opcode = op; r.slice_index = s[4:0];
    r.x_value = x[23:0]; r.y_value = y[23:0]; r.z_value = z[23:0];
    r.x_square = xs; r.y_square = ys; r.z_square = zs;
    return r;
  endfunction

  function automatic logic [45:0] square_of(logic signed [23:0] v);
    longint unsigned p;
    p = longint'(v) * longint'(v);
    return (p > SQ_MAX) ? SQ_MAX : p[45:0];
  endfunction

  // Random payload: mostly consistent samples, some raw bits, some with
  // squares too small (negative variance).
  function automatic req_t random_request(int slice_span, int normalize_pct);
    req_t r;
    logic signed [23:0] v [3];
    logic [45:0] sq [3];
    int kind;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) begin
      v[i] = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($signed(14'($urandom())));
      if (kind < 70) sq[i] = square_of(v[i]) + $urandom_range(0, 255);
      else if (kind < 85) sq[i] = 46'({$urandom(), $urandom()});
      else sq[i] = square_of(v[i]) >> $urandom_range(1, 8);
    end
    r.opcode = ($urandom_range(0, 99) < normalize_pct) ? OP_NORMALIZE : OP_ACCUMULATE;
    r.slice_index = 5'($urandom_range(0, slice_span - 1));
    r.x_value = v[0]; r.y_value = v[1]; r.z_value = v[2];
    r.x_square = sq[0]; r.y_square = sq[1]; r.z_square = sq[2];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Test tasks
  // ---------------------------------------------------------------------

  // Field extremes, both opcodes and mean saturation in both directions.
  task automatic test_field_extremes;
    send_request(make_request(OP_ACCUMULATE, 0, 8388607, -8388608, 0,
                              SQ_MAX, SQ_MAX, '0));
    send_request(make_request(OP_NORMALIZE, 0, 0, 0, 0, '0, '0, '0));
    repeat (2) send_request(make_request(OP_ACCUMULATE, 31, -8388608, 8388607, -1,
                                         square_of(-24'sd8388608), SQ_MAX, 46'd1));
    send_request(make_request(OP_NORMALIZE, 31, -1, -1, -1, SQ_MAX, SQ_MAX, SQ_MAX));
    send_request(make_request(OP_NORMALIZE, 5, 0, 0, 0, '0, '0, '0));  // empty slice
    drain();
  endtask

  // Negative variance beyond and within tolerance, and an exact square.
  task automatic test_negative_variance;
    send_request(make_request(OP_ACCUMULATE, 2, 4096, 1, 5, '0, '0, 46'd25));
    send_request(make_request(OP_NORMALIZE, 2, 0, 0, 0, '0, '0, '0));
    send_request(make_request(OP_ACCUMULATE, 3, -4, 4, 2, 46'd15, 46'd0, 46'd4));
    send_request(make_request(OP_NORMALIZE, 3, 0, 0, 0, '0, '0, '0));
    drain();
  endtask

  // Deviation and mean magnitude past 24 bits.
  task automatic test_deviation_saturation;
    repeat (8) send_request(make_request(OP_ACCUMULATE, 4, 0, 0, 0,
                                         SQ_MAX, SQ_MAX, SQ_MAX));
    send_request(make_request(OP_NORMALIZE, 4, 0, 0, 0, '0, '0, '0));
    drain();
  endtask

  task automatic test_random(int count, int slice_span, int normalize_pct);
    repeat (count) send_request(random_request(slice_span, normalize_pct));
    drain();
  endtask

  // Hold the result side off for a long stretch while requests keep coming,
  // so the unit parks with a result and stalls its input.
  task automatic test_result_holdoff;
    holdoff_request = HOLDOFF_CYCLES;
    repeat (40) send_request(random_request(4, 30));
    drain();
  endtask

  // Pause the sender until every owed result is back, then resume.
  task automatic test_sender_pause;
    repeat (30) send_request(random_request(8, 20));
    req_valid <= 1'b0;
    burst_left = 0;
    while (due_stats.size() != 0) @(posedge clk);
    @(posedge clk);
    test_random(30, 8, 20);
  endtask

  // ---------------------------------------------------------------------
  // Result side: own stall pattern, plus a long hold-off on request.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      holdoff_left = 0;
      pattern_left = 0;
      stall_pct = 0;
    end else begin
      if (holdoff_request > 0) begin
        holdoff_left = holdoff_request;
        holdoff_request = 0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        rsp_stall <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(20, 400);
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 50;
            default: stall_pct = 90;
          endcase
        end else begin
          pattern_left--;
        end
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %h actual %h", $time, field, want, got);
      errors++;
    end
  endfunction

  // Sample at the falling edge: what holds here is taken at the next rising edge.
  always @(negedge clk) begin
    rsp_t want;
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (rsp_valid && !rsp_stall) begin
        results_seen++;
        if (rsp_data.negative_variance_flags != 0) flagged_results++;
        if (due_stats.size() == 0) begin
          $display("%0t unexpected result for slice %0d", $time, rsp_data.result_slice);
          errors++;
        end else begin
          want = due_stats.pop_front();
          compare_field("result_slice", want.result_slice, rsp_data.result_slice);
          compare_field("mean_x", want.mean_x, rsp_data.mean_x);
          compare_field("mean_y", want.mean_y, rsp_data.mean_y);
          compare_field("mean_z", want.mean_z, rsp_data.mean_z);
          compare_field("mean_magnitude", want.mean_magnitude, rsp_data.mean_magnitude);
          compare_field("sdev_x", want.sdev_x, rsp_data.sdev_x);
          compare_field("sdev_y", want.sdev_y, rsp_data.sdev_y);
          compare_field("sdev_z", want.sdev_z, rsp_data.sdev_z);
          compare_field("sdev_magnitude", want.sdev_magnitude, rsp_data.sdev_magnitude);
          compare_field("negative_variance_flags", want.negative_variance_flags,
                        rsp_data.negative_variance_flags);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    errors = 0; requests_sent = 0; normalizes_sent = 0;
    results_seen = 0; flagged_results = 0;
    burst_left = 0; idle_cycles = 0; holdoff_request = 0;
    cfg_count = SAMPLE_COUNT_RESET;
    cfg_tolerance = TOLERANCE_RESET;
    for (int s = 0; s < SLICES; s++) clear_sums(s);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset register values first
    test_field_extremes();
    test_negative_variance();
    test_deviation_saturation();

    write_register(REG_TOLERANCE, 16'd0);
    test_negative_variance();
    test_random(150, 4, 25);

    write_register(REG_SAMPLE_COUNT, 16'd4);
    write_register(REG_TOLERANCE, 16'hFFFF);
    test_random(150, 8, 15);
    test_result_holdoff();

    write_register(REG_SAMPLE_COUNT, 16'd0);   // treated as one
    write_register(REG_TOLERANCE, 16'd17);
    test_field_extremes();
    test_random(120, 32, 12);

    write_register(REG_SAMPLE_COUNT, 16'hFFFF);
    write_register(REG_TOLERANCE, 16'($urandom()));
    test_random(120, 4, 10);

    write_register(REG_SAMPLE_COUNT, 16'($urandom_range(2, 16)));
    write_register(REG_TOLERANCE, 16'($urandom_range(0, 300)));
    test_sender_pause();
    test_random(200, 16, 15);

    $display("covered %0d requests (%0d normalizes), %0d results checked, %0d flagged",
             requests_sent, normalizes_sent, results_seen, flagged_results);
    $display("register settings swept: counts 1, 4, 0, 65535, random; tolerance 0 to max");
    if (errors == 0 && due_stats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d errors, %0d results never arrived", errors, due_stats.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
